// ===== hw/rtl/lfu_slot_replacement_assert.svh =====
// assertion macros for the lfu slot replacement block
`ifndef LFU_SLOT_REPLACEMENT_ASSERT_SVH
`define LFU_SLOT_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define LFUSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFUSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfusr_pkg.sv =====
// shared types and constants of the lfu slot replacement block
package lfusr_pkg;

    localparam int NUM_SLOTS   = 32;
    localparam int COUNT_BITS  = 16;
    localparam int STAMP_BITS  = 32;
    localparam int ID_BITS     = 16;
    localparam int IDX_BITS    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FILL_BITS   = $clog2(NUM_SLOTS + 1);
    localparam int ENTRY_BITS  = ID_BITS + COUNT_BITS + STAMP_BITS;
    localparam int ACTIVE_BITS = 6;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    typedef logic [ID_BITS-1:0]     t_id;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [STAMP_BITS-1:0]  t_stamp;
    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [FILL_BITS-1:0]   t_fill;
    typedef logic [ACTIVE_BITS-1:0] t_active;
    typedef logic [1:0]             t_outcome;

    localparam t_outcome OUT_HIT     = 2'd0;
    localparam t_outcome OUT_FILL    = 2'd1;
    localparam t_outcome OUT_REPLACE = 2'd2;

    localparam t_count  COUNT_MAX    = '1;
    localparam t_stamp  STAMP_MAX    = '1;
    localparam t_active ACTIVE_RESET = t_active'(32);

    // word index of the active_slots register
    localparam logic REG_ACTIVE = 1'b0;

    typedef struct packed {
        t_stamp stamp;
        t_count hits;
        t_id    ident;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr;
    } t_mem_req;

    typedef struct packed {
        t_outcome outcome;
        t_idx     slot;
        t_id      evicted;
        t_count   count;
    } t_result;

endpackage

// ===== hw/rtl/lfusr_ram.sv =====
// generic single-port-write, registered-read ram
module lfusr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lfusr_engine.sv =====
// scan and update sequencer of the lfu slot table
module lfusr_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lfusr_pkg::t_id      i_id,
    input  lfusr_pkg::t_active  i_active,
    output logic                o_busy,
    output lfusr_pkg::t_mem_req o_mem,
    input  lfusr_pkg::t_entry   i_rdata,
    output logic                o_valid,
    output lfusr_pkg::t_result  o_result
);
    import lfusr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] r_state;
    t_stamp     r_stamp;
    t_fill      r_filled;
    t_fill      r_k;
    logic       r_rv;
    logic       r_found;
    logic       r_vvalid;
    logic       r_valid;

    t_id        r_id;
    t_stamp     r_now;
    t_fill      r_limit;
    t_idx       r_rk;
    t_idx       r_mslot;
    t_entry     r_mentry;
    t_idx       r_vslot;
    t_entry     r_ventry;
    t_result    r_result;

    t_fill      w_limit;
    logic       w_issue;
    logic       w_match;
    logic       w_better;
    logic       w_take;
    logic       w_fill;
    t_count     w_hits;
    t_entry     w_entry;
    t_idx       w_slot;
    t_result    w_res;

    always_comb begin
        if (i_active == '0) begin
            w_limit = t_fill'(1);
        end else if (int'(i_active) > NUM_SLOTS) begin
            w_limit = t_fill'(NUM_SLOTS);
        end else begin
            w_limit = t_fill'(i_active);
        end
    end

    assign w_issue  = (r_state == ST_SCAN) && (r_k < r_filled);
    assign w_match  = r_rv && !r_found && (i_rdata.ident == r_id);
    assign w_better = !r_vvalid || (i_rdata.hits < r_ventry.hits) ||
                      ((i_rdata.hits == r_ventry.hits) && (i_rdata.stamp < r_ventry.stamp));
    assign w_take   = r_rv && (t_fill'(r_rk) < r_limit) && w_better;
    assign w_fill   = !r_found && (r_filled < r_limit);

    // decide hit, fill or replace
    always_comb begin
        w_hits = (r_mentry.hits == COUNT_MAX) ? r_mentry.hits : r_mentry.hits + t_count'(1);
        w_entry.ident = r_id;
        w_entry.hits  = t_count'(1);
        w_entry.stamp = r_now;
        w_res.evicted = '0;
        priority if (r_found) begin
            w_slot        = r_mslot;
            w_entry.hits  = w_hits;
            w_entry.stamp = r_mentry.stamp;
            w_res.outcome = OUT_HIT;
        end else if (w_fill) begin
            w_slot        = r_filled[IDX_BITS-1:0];
            w_res.outcome = OUT_FILL;
        end else begin
            w_slot        = r_vslot;
            w_res.evicted = r_ventry.ident;
            w_res.outcome = OUT_REPLACE;
        end
        w_res.slot  = w_slot;
        w_res.count = w_entry.hits;
    end

    assign o_mem.we    = (r_state == ST_WRITE);
    assign o_mem.waddr = w_slot;
    assign o_mem.wdata = w_entry;
    assign o_mem.raddr = r_k[IDX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stamp  <= '0;
            r_filled <= '0;
            r_k      <= '0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
            r_vvalid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_rv    <= w_issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        if (r_stamp != STAMP_MAX) begin
                            r_stamp <= r_stamp + t_stamp'(1);
                        end
                        r_k      <= '0;
                        r_found  <= 1'b0;
                        r_vvalid <= 1'b0;
                        r_state  <= (r_filled == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_k <= r_k + t_fill'(1);
                    end
                    if (w_match) begin
                        r_found <= 1'b1;
                    end
                    if (w_take) begin
                        r_vvalid <= 1'b1;
                    end
                    if (!w_issue && !r_rv) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_valid <= 1'b1;
                    if (w_fill) begin
                        r_filled <= r_filled + t_fill'(1);
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_id    <= i_id;
            r_now   <= r_stamp;
            r_limit <= w_limit;
        end
        r_rk <= r_k[IDX_BITS-1:0];
        if (w_match) begin
            r_mslot  <= r_rk;
            r_mentry <= i_rdata;
        end
        if (w_take) begin
            r_vslot  <= r_rk;
            r_ventry <= i_rdata;
        end
        if (r_state == ST_WRITE) begin
            r_result <= w_res;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/lfu_slot_replacement.sv =====
// top level of the lfu slot replacement block: config register, table ram, sequencer
// an item scans the filled slots (up to 32, none when the table is empty), then writes back
// and shows its result strobe
// the table ram is read one slot per cycle, then the write-back follows
// busy drops in the cycle the result is shown and a new word is taken at the edge ending
// it; no new word is taken while busy, and results never stall
// reset clears fill count, arrival stamp and control, sets active_slots to 32, ram kept
module lfu_slot_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       i_candidate_id,
    output logic                              o_valid,
    output logic [1:0]                        o_outcome,
    output logic [4:0]                        o_slot_index,
    output logic [15:0]                       o_evicted_id,
    output logic [15:0]                       o_entry_count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfusr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [lfusr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [lfusr_pkg::DATA_BITS-1:0]   prdata,
    output logic                              pready
);
    import lfusr_pkg::*;

    t_active  r_active;
    t_mem_req w_mem;
    t_entry   w_rdata;
    t_result  w_res;
    logic     w_wr;

    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_ACTIVE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE) ? DATA_BITS'(r_active) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (w_wr) begin
            r_active <= pwdata[ACTIVE_BITS-1:0];
        end
    end

    lfusr_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    lfusr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_id     (i_candidate_id),
        .i_active (r_active),
        .o_busy   (busy),
        .o_mem    (w_mem),
        .i_rdata  (w_rdata),
        .o_valid  (o_valid),
        .o_result (w_res)
    );

    assign o_outcome     = w_res.outcome;
    assign o_slot_index  = 5'(w_res.slot);
    assign o_evicted_id  = w_res.evicted;
    assign o_entry_count = 16'(w_res.count);

endmodule

// ===== hw/rtl/lfusr_checker.sv =====
// port-level assertions for the lfu slot replacement block
`include "lfu_slot_replacement_assert.svh"

module lfusr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_outcome,
    input logic [15:0] o_evicted_id,
    input logic [15:0] o_entry_count
);
    import lfusr_pkg::*;

    `LFUSR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word did not raise busy")
    `LFUSR_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `LFUSR_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")
    `LFUSR_ASSERT_IMP(a_evict_zero, i_clk, i_rst_n, o_valid && (o_outcome != OUT_REPLACE), o_evicted_id == '0, "evicted id set without replacement")
    `LFUSR_ASSERT_IMP(a_count_pos, i_clk, i_rst_n, o_valid, o_entry_count != '0, "zero count on result")

endmodule

bind lfu_slot_replacement lfusr_checker u_checker (.*);
